// ----- rtl/rbf_pkg.sv -----
package rbf_pkg;

  localparam int unsigned KindW   = 3;
  localparam int unsigned HandleW = 64;
  localparam int unsigned SlotW   = 8;
  localparam int unsigned OffsetW = 64;
  localparam int unsigned IdxKW   = 8;
  localparam int unsigned CountW  = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 5;
  localparam int unsigned SetCntW = 4;
  localparam int unsigned VbCntW  = 5;
  localparam int unsigned NumBindKinds = 4;

  typedef enum logic [KindW-1:0] {
    KindPipeline   = 3'd0,
    KindDescSet    = 3'd1,
    KindVertexBuf  = 3'd2,
    KindIndexBuf   = 3'd3,
    KindPushDirty  = 3'd4,
    KindInvalidate = 3'd5,
    KindResetStats = 3'd6
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgTrackStats    = 2'd0,
    CfgSetsInUse     = 2'd1,
    CfgBindingsInUse = 2'd2
  } cfg_idx_e;

  typedef logic [CountW-1:0] count_t;

endpackage

// ----- rtl/redundant_bind_filter.sv -----
// Redundant bind filter. Each command beat (pipeline, descriptor set, vertex buffer, index
// buffer, push-constant dirty, invalidate, reset statistics) is checked against the bound
// state kept in flops and answered with one result beat: whether the bind must be sent,
// the bound pipeline, the descriptor handle in the addressed slot and the per-kind and
// total issued/avoided counters. The block takes one command per clock unless the output
// stalls; each beat passes the input register, then compare-and-update into the result
// register, and both the input and result stages hold under output back-pressure.
// Descriptor and vertex slots at or beyond the configured count are always issued and not
// stored. Invalidate clears all bindings at once through per-slot valid bits.
// Configuration writes take effect at once and are expected only while no beat is in flight.
module redundant_bind_filter #(
  parameter int unsigned MAX_SETS   = 8,
  parameter int unsigned MAX_VBINDS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,

  input  logic                            cfg_we_i,
  input  logic [rbf_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [rbf_pkg::CfgW-1:0]        cfg_data_i,

  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [rbf_pkg::KindW-1:0]       kind_i,
  input  logic [rbf_pkg::HandleW-1:0]     handle_i,
  input  logic [rbf_pkg::SlotW-1:0]       slot_i,
  input  logic [rbf_pkg::OffsetW-1:0]     buf_offset_i,
  input  logic [rbf_pkg::IdxKW-1:0]       index_kind_i,

  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            issue_o,
  output logic                            push_dirty_o,
  output logic [rbf_pkg::HandleW-1:0]     current_pipeline_o,
  output logic [rbf_pkg::HandleW-1:0]     slot_handle_o,
  output logic [rbf_pkg::CountW-1:0]      kind_issued_o,
  output logic [rbf_pkg::CountW-1:0]      kind_avoided_o,
  output logic [rbf_pkg::CountW-1:0]      total_issued_o,
  output logic [rbf_pkg::CountW-1:0]      total_avoided_o
);
  import rbf_pkg::*;

  localparam int unsigned SetIdxW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int unsigned VbIdxW  = (MAX_VBINDS > 1) ? $clog2(MAX_VBINDS) : 1;
  localparam logic [SlotW-1:0] MaxSetsS = SlotW'(MAX_SETS);
  localparam logic [SlotW-1:0] MaxVbS   = SlotW'(MAX_VBINDS);

  // configuration
  logic               track_q;
  logic [SetCntW-1:0] sets_q;
  logic [VbCntW-1:0]  vbs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      track_q <= 1'b1;
      sets_q  <= SetCntW'(8);
      vbs_q   <= VbCntW'(16);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgTrackStats:    track_q <= cfg_data_i[0];
        CfgSetsInUse:     sets_q  <= cfg_data_i[SetCntW-1:0];
        CfgBindingsInUse: vbs_q   <= cfg_data_i[VbCntW-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  logic s1_vld_q, out_vld_q;
  logic adv, fire, in_acc;

  assign adv        = !out_vld_q || out_ready_i;
  assign fire       = s1_vld_q && adv;
  assign in_ready_o = !s1_vld_q || adv;
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_vld_q <= 1'b1;
      end else if (fire) begin
        s1_vld_q <= 1'b0;
      end
      if (adv) begin
        out_vld_q <= s1_vld_q;
      end
    end
  end

  // input register
  logic [KindW-1:0]   s1_kind_q;
  logic [HandleW-1:0] s1_handle_q;
  logic [SlotW-1:0]   s1_slot_q;
  logic [OffsetW-1:0] s1_offset_q;
  logic [IdxKW-1:0]   s1_itype_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_kind_q   <= kind_i;
      s1_handle_q <= handle_i;
      s1_slot_q   <= slot_i;
      s1_offset_q <= buf_offset_i;
      s1_itype_q  <= index_kind_i;
    end
  end

  // bound state
  logic [HandleW-1:0] pipe_q;
  logic               pipe_vld_q;
  logic [HandleW-1:0] set_tab_q [MAX_SETS];
  logic [MAX_SETS-1:0] set_vld_q;
  logic [HandleW-1:0] vb_hdl_q [MAX_VBINDS];
  logic [OffsetW-1:0] vb_off_q [MAX_VBINDS];
  logic [MAX_VBINDS-1:0] vb_vld_q;
  logic [HandleW-1:0] ib_hdl_q;
  logic [OffsetW-1:0] ib_off_q;
  logic [IdxKW-1:0]   ib_type_q;
  logic               ib_vld_q;
  logic               dirty_q;
  count_t             iss_q [NumBindKinds];
  count_t             avd_q [NumBindKinds];
  count_t             push_cnt_q, tot_iss_q, tot_avd_q;

  // compare and update
  kind_e              kind;
  logic [SlotW-1:0]   set_lim, vb_lim;
  logic               set_in, vb_in;
  logic [SetIdxW-1:0] set_idx;
  logic [VbIdxW-1:0]  vb_idx;
  logic [HandleW-1:0] set_cur, vb_hcur;
  logic [OffsetW-1:0] vb_ocur;
  logic               hnz;
  logic               issue;
  logic               tally;
  logic [1:0]         tk;
  logic               pipe_we, set_we, vb_we, ib_we, clr_all, clr_stats, push_inc;
  logic               dirty_d;
  count_t             iss_d [NumBindKinds];
  count_t             avd_d [NumBindKinds];
  count_t             push_cnt_d, tot_iss_d, tot_avd_d;
  count_t             k_iss, k_avd;
  logic [HandleW-1:0] cur_pipe, slot_hdl;

  assign kind = kind_e'(s1_kind_q);
  assign hnz  = |s1_handle_q;

  always_comb begin
    set_lim = ({4'b0, sets_q} > MaxSetsS) ? MaxSetsS : {4'b0, sets_q};
    vb_lim  = ({3'b0, vbs_q} > MaxVbS) ? MaxVbS : {3'b0, vbs_q};
    set_in  = s1_slot_q < set_lim;
    vb_in   = s1_slot_q < vb_lim;
    set_idx = s1_slot_q[SetIdxW-1:0];
    vb_idx  = s1_slot_q[VbIdxW-1:0];
    set_cur = (set_in && set_vld_q[set_idx]) ? set_tab_q[set_idx] : '0;
    vb_hcur = (vb_in && vb_vld_q[vb_idx]) ? vb_hdl_q[vb_idx] : '0;
    vb_ocur = (vb_in && vb_vld_q[vb_idx]) ? vb_off_q[vb_idx] : '0;

    issue     = 1'b0;
    tally     = 1'b0;
    pipe_we   = 1'b0;
    set_we    = 1'b0;
    vb_we     = 1'b0;
    ib_we     = 1'b0;
    clr_all   = 1'b0;
    clr_stats = 1'b0;
    push_inc  = 1'b0;
    tk        = s1_kind_q[1:0];

    case (kind)
      KindPipeline: begin
        tally = 1'b1;
        issue = !(pipe_vld_q && pipe_q == s1_handle_q);
        pipe_we = issue;
      end
      KindDescSet: begin
        if (!set_in) begin
          issue = 1'b1;
        end else begin
          tally  = 1'b1;
          issue  = !(set_cur == s1_handle_q && hnz);
          set_we = issue;
        end
      end
      KindVertexBuf: begin
        if (!vb_in) begin
          issue = 1'b1;
        end else begin
          tally = 1'b1;
          issue = !(vb_hcur == s1_handle_q && vb_ocur == s1_offset_q && hnz);
          vb_we = issue;
        end
      end
      KindIndexBuf: begin
        tally = 1'b1;
        issue = !(ib_vld_q && ib_hdl_q == s1_handle_q && ib_off_q == s1_offset_q &&
                  ib_type_q == s1_itype_q);
        ib_we = issue;
      end
      KindPushDirty:  push_inc  = 1'b1;
      KindInvalidate: clr_all   = 1'b1;
      KindResetStats: clr_stats = 1'b1;
      default: ;
    endcase

    dirty_d = dirty_q || pipe_we || push_inc || clr_all;

    iss_d      = iss_q;
    avd_d      = avd_q;
    push_cnt_d = push_cnt_q;
    tot_iss_d  = tot_iss_q;
    tot_avd_d  = tot_avd_q;
    if (clr_stats) begin
      for (int i = 0; i < NumBindKinds; i++) begin
        iss_d[i] = '0;
        avd_d[i] = '0;
      end
      push_cnt_d = '0;
      tot_iss_d  = '0;
      tot_avd_d  = '0;
    end else if (track_q) begin
      if (tally && issue) begin
        iss_d[tk] = iss_q[tk] + 1'b1;
        tot_iss_d = tot_iss_q + 1'b1;
      end else if (tally) begin
        avd_d[tk] = avd_q[tk] + 1'b1;
        tot_avd_d = tot_avd_q + 1'b1;
      end
      if (push_inc) begin
        push_cnt_d = push_cnt_q + 1'b1;
      end
    end

    k_iss = '0;
    k_avd = '0;
    if (!s1_kind_q[2]) begin
      k_iss = iss_d[tk];
      k_avd = avd_d[tk];
    end else if (kind == KindPushDirty) begin
      k_iss = push_cnt_d;
    end

    // values as they stand after this command
    if (clr_all) begin
      cur_pipe = '0;
    end else if (pipe_we) begin
      cur_pipe = s1_handle_q;
    end else begin
      cur_pipe = pipe_vld_q ? pipe_q : '0;
    end
    if (clr_all) begin
      slot_hdl = '0;
    end else if (set_we) begin
      slot_hdl = s1_handle_q;
    end else begin
      slot_hdl = set_cur;
    end
  end

  // binding tables, valid bits gate the contents
  always_ff @(posedge clk_i) begin
    if (fire && pipe_we) begin
      pipe_q <= s1_handle_q;
    end
    if (fire && set_we) begin
      set_tab_q[set_idx] <= s1_handle_q;
    end
    if (fire && vb_we) begin
      vb_hdl_q[vb_idx] <= s1_handle_q;
      vb_off_q[vb_idx] <= s1_offset_q;
    end
    if (fire && ib_we) begin
      ib_hdl_q  <= s1_handle_q;
      ib_off_q  <= s1_offset_q;
      ib_type_q <= s1_itype_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_vld_q <= 1'b0;
      set_vld_q  <= '0;
      vb_vld_q   <= '0;
      ib_vld_q   <= 1'b0;
      dirty_q    <= 1'b1;
      for (int i = 0; i < NumBindKinds; i++) begin
        iss_q[i] <= '0;
        avd_q[i] <= '0;
      end
      push_cnt_q <= '0;
      tot_iss_q  <= '0;
      tot_avd_q  <= '0;
    end else if (fire) begin
      if (clr_all) begin
        pipe_vld_q <= 1'b0;
        set_vld_q  <= '0;
        vb_vld_q   <= '0;
        ib_vld_q   <= 1'b0;
      end else begin
        if (pipe_we) pipe_vld_q <= 1'b1;
        if (set_we) set_vld_q[set_idx] <= 1'b1;
        if (vb_we) vb_vld_q[vb_idx] <= 1'b1;
        if (ib_we) ib_vld_q <= 1'b1;
      end
      dirty_q    <= dirty_d;
      iss_q      <= iss_d;
      avd_q      <= avd_d;
      push_cnt_q <= push_cnt_d;
      tot_iss_q  <= tot_iss_d;
      tot_avd_q  <= tot_avd_d;
    end
  end

  // result register
  logic               issue_q, dirty_out_q;
  logic [HandleW-1:0] cur_pipe_q, slot_hdl_q;
  count_t             k_iss_q, k_avd_q, tot_iss_out_q, tot_avd_out_q;

  always_ff @(posedge clk_i) begin
    if (fire) begin
      issue_q       <= issue;
      dirty_out_q   <= dirty_d;
      cur_pipe_q    <= cur_pipe;
      slot_hdl_q    <= slot_hdl;
      k_iss_q       <= k_iss;
      k_avd_q       <= k_avd;
      tot_iss_out_q <= tot_iss_d;
      tot_avd_out_q <= tot_avd_d;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign issue_o            = issue_q;
  assign push_dirty_o       = dirty_out_q;
  assign current_pipeline_o = cur_pipe_q;
  assign slot_handle_o      = slot_hdl_q;
  assign kind_issued_o      = k_iss_q;
  assign kind_avoided_o     = k_avd_q;
  assign total_issued_o     = tot_iss_out_q;
  assign total_avoided_o    = tot_avd_out_q;

  // nothing ever clears the dirty flag
  a_dirty_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> push_dirty_o)
    else $error("push dirty flag dropped");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_vld_q && out_vld_q && !out_ready_i))
    else $error("input stalled with room in the pipe");

  a_stats_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !track_q && kind != KindResetStats) |=>
      ($stable(tot_iss_q) && $stable(tot_avd_q) && $stable(push_cnt_q)))
    else $error("counters moved with statistics off");

  a_invalidate_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && kind == KindInvalidate) |=>
      (!pipe_vld_q && !ib_vld_q && set_vld_q == '0 && vb_vld_q == '0))
    else $error("invalidate left a binding valid");

endmodule

// ----- sim/redundant_bind_filter_test.sv -----
`timescale 1ns / 1ps

module redundant_bind_filter_test;
  import rbf_pkg::*;

  localparam int unsigned MaxSets    = 8;
  localparam int unsigned MaxVbinds  = 16;
  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned PhaseItems = 165;

  typedef struct packed {
    kind_e              kind;
    logic [HandleW-1:0] handle;
    logic [SlotW-1:0]   slot;
    logic [OffsetW-1:0] buf_offset;
    logic [IdxKW-1:0]   index_kind;
  } bind_cmd_t;

  typedef struct packed {
    logic               issue;
    logic               push_dirty;
    logic [HandleW-1:0] current_pipeline;
    logic [HandleW-1:0] slot_handle;
    count_t             kind_issued;
    count_t             kind_avoided;
    count_t             total_issued;
    count_t             total_avoided;
  } bind_verdict_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0]    cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [KindW-1:0]   kind_i;
  logic [HandleW-1:0] handle_i;
  logic [SlotW-1:0]   slot_i;
  logic [OffsetW-1:0] buf_offset_i;
  logic [IdxKW-1:0]   index_kind_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               issue_o;
  logic               push_dirty_o;
  logic [HandleW-1:0] current_pipeline_o;
  logic [HandleW-1:0] slot_handle_o;
  count_t             kind_issued_o;
  count_t             kind_avoided_o;
  count_t             total_issued_o;
  count_t             total_avoided_o;

  redundant_bind_filter #(
    .MAX_SETS  (MaxSets),
    .MAX_VBINDS(MaxVbinds)
  ) i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .kind_i            (kind_i),
    .handle_i          (handle_i),
    .slot_i            (slot_i),
    .buf_offset_i      (buf_offset_i),
    .index_kind_i      (index_kind_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .issue_o           (issue_o),
    .push_dirty_o      (push_dirty_o),
    .current_pipeline_o(current_pipeline_o),
    .slot_handle_o     (slot_handle_o),
    .kind_issued_o     (kind_issued_o),
    .kind_avoided_o    (kind_avoided_o),
    .total_issued_o    (total_issued_o),
    .total_avoided_o   (total_avoided_o)
  );

  // shadow of the bound state
  logic [HandleW-1:0] pipe_hdl;
  logic               pipe_valid;
  logic [HandleW-1:0] set_tbl [MaxSets];
  logic [HandleW-1:0] vb_hdl  [MaxVbinds];
  logic [OffsetW-1:0] vb_off  [MaxVbinds];
  logic [HandleW-1:0] ib_hdl;
  logic [OffsetW-1:0] ib_off;
  logic [IdxKW-1:0]   ib_type;
  logic               ib_valid;
  logic               dirty;
  count_t             issued_cnt  [NumBindKinds];
  count_t             avoided_cnt [NumBindKinds];
  count_t             push_cnt;
  logic               cfg_track;
  logic [SetCntW-1:0] cfg_sets;
  logic [VbCntW-1:0]  cfg_binds;

  bind_cmd_t     cmd_q[$];
  bind_verdict_t verdict_q[$];
  bind_cmd_t     cur_cmd;
  logic          cmd_taken;
  int unsigned   send_idle_pct;
  int unsigned   recv_idle_pct;
  logic          hold_req;
  logic          hold_ack;
  int unsigned   hold_left;
  int unsigned   quiet_cycles;
  int unsigned   fail_count;
  logic [HandleW-1:0] hdl_pool [4];
  logic [OffsetW-1:0] off_pool [2];
  logic [IdxKW-1:0]   ikind_pool [2];

  always #1 clk_i = ~clk_i;

  function automatic void clear_bindings();
    pipe_hdl   = '0;
    pipe_valid = 1'b0;
    for (int i = 0; i < MaxSets; i++) set_tbl[i] = '0;
    for (int i = 0; i < MaxVbinds; i++) begin
      vb_hdl[i] = '0;
      vb_off[i] = '0;
    end
    ib_hdl   = '0;
    ib_off   = '0;
    ib_type  = '0;
    ib_valid = 1'b0;
    dirty    = 1'b1;
  endfunction

  function automatic void clear_counts();
    for (int i = 0; i < NumBindKinds; i++) begin
      issued_cnt[i]  = '0;
      avoided_cnt[i] = '0;
    end
    push_cnt = '0;
  endfunction

  function automatic void tally(int unsigned k, logic sent);
    if (cfg_track) begin
      if (sent) issued_cnt[k] = issued_cnt[k] + 1'b1;
      else avoided_cnt[k] = avoided_cnt[k] + 1'b1;
    end
  endfunction

  // applies one command to the shadow state and returns what the block must answer
  function automatic bind_verdict_t filter_bind(bind_cmd_t c);
    bind_verdict_t v;
    int unsigned   set_lim;
    int unsigned   vb_lim;
    int unsigned   k;
    logic          hit;
    v       = '0;
    set_lim = (cfg_sets < MaxSets) ? cfg_sets : MaxSets;
    vb_lim  = (cfg_binds < MaxVbinds) ? cfg_binds : MaxVbinds;
    k       = int'(c.kind);
    case (c.kind)
      KindPipeline: begin
        hit = pipe_valid && (pipe_hdl == c.handle);
        if (!hit) begin
          pipe_hdl   = c.handle;
          pipe_valid = 1'b1;
          dirty      = 1'b1;
        end
        tally(0, !hit);
        v.issue = !hit;
      end
      KindDescSet: begin
        if (c.slot >= set_lim) begin
          v.issue = 1'b1;
        end else begin
          hit = (set_tbl[c.slot] == c.handle) && (c.handle != '0);
          if (!hit) set_tbl[c.slot] = c.handle;
          tally(1, !hit);
          v.issue = !hit;
        end
      end
      KindVertexBuf: begin
        if (c.slot >= vb_lim) begin
          v.issue = 1'b1;
        end else begin
          hit = (vb_hdl[c.slot] == c.handle) && (vb_off[c.slot] == c.buf_offset) &&
                (c.handle != '0);
          if (!hit) begin
            vb_hdl[c.slot] = c.handle;
            vb_off[c.slot] = c.buf_offset;
          end
          tally(2, !hit);
          v.issue = !hit;
        end
      end
      KindIndexBuf: begin
        hit = ib_valid && (ib_hdl == c.handle) && (ib_off == c.buf_offset) &&
              (ib_type == c.index_kind);
        if (!hit) begin
          ib_hdl   = c.handle;
          ib_off   = c.buf_offset;
          ib_type  = c.index_kind;
          ib_valid = 1'b1;
        end
        tally(3, !hit);
        v.issue = !hit;
      end
      KindPushDirty: begin
        dirty = 1'b1;
        if (cfg_track) push_cnt = push_cnt + 1'b1;
      end
      KindInvalidate: clear_bindings();
      KindResetStats: clear_counts();
      default: ;
    endcase
    if (k < NumBindKinds) begin
      v.kind_issued  = issued_cnt[k];
      v.kind_avoided = avoided_cnt[k];
    end else if (c.kind == KindPushDirty) begin
      v.kind_issued = push_cnt;
    end
    v.push_dirty       = dirty;
    v.current_pipeline = pipe_valid ? pipe_hdl : '0;
    v.slot_handle      = (c.slot < set_lim) ? set_tbl[c.slot] : '0;
    v.total_issued     = issued_cnt[0] + issued_cnt[1] + issued_cnt[2] + issued_cnt[3];
    v.total_avoided    = avoided_cnt[0] + avoided_cnt[1] + avoided_cnt[2] + avoided_cnt[3];
    return v;
  endfunction

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // command driver
  always @(negedge clk_i) begin : drive_cmd
    bind_cmd_t c;
    if (rst_ni && !(in_valid_i && !cmd_taken)) begin
      if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        c             = cmd_q.pop_front();
        cur_cmd       = c;
        in_valid_i   <= 1'b1;
        kind_i       <= c.kind;
        handle_i     <= c.handle;
        slot_i       <= c.slot;
        buf_offset_i <= c.buf_offset;
        index_kind_i <= c.index_kind;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result receiver, with a long hold-off on request
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_ack != hold_req) begin
        hold_ack  = hold_req;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // monitor and watchdog
  always @(posedge clk_i) begin : watch_beats
    bind_verdict_t exp_v;
    if (rst_ni) begin
      cmd_taken <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) verdict_q.push_back(filter_bind(cur_cmd));
      if (out_valid_o && out_ready_i) begin
        if (verdict_q.size() == 0) begin
          $error("result beat with no command pending");
          fail_count++;
        end else begin
          exp_v = verdict_q.pop_front();
          check_field("issue", exp_v.issue, issue_o);
          check_field("push_dirty", exp_v.push_dirty, push_dirty_o);
          check_field("current_pipeline", exp_v.current_pipeline, current_pipeline_o);
          check_field("slot_handle", exp_v.slot_handle, slot_handle_o);
          check_field("kind_issued", exp_v.kind_issued, kind_issued_o);
          check_field("kind_avoided", exp_v.kind_avoided, kind_avoided_o);
          check_field("total_issued", exp_v.total_issued, total_issued_o);
          check_field("total_avoided", exp_v.total_avoided, total_avoided_o);
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic push_cmd(kind_e k, logic [HandleW-1:0] h, logic [SlotW-1:0] s,
                          logic [OffsetW-1:0] o, logic [IdxKW-1:0] ik);
    bind_cmd_t c;
    c.kind       = k;
    c.handle     = h;
    c.slot       = s;
    c.buf_offset = o;
    c.index_kind = ik;
    cmd_q.push_back(c);
  endtask

  // wait until every accepted command has answered, then let the pipe settle
  task automatic drain();
    while (cmd_q.size() != 0 || in_valid_i || verdict_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic program_filter(logic track, logic [CfgW-1:0] sets, logic [CfgW-1:0] binds);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgTrackStats;
    cfg_data_i <= {{(CfgW-1){1'b0}}, track};
    cfg_track   = track;
    @(negedge clk_i);
    cfg_idx_i  <= CfgSetsInUse;
    cfg_data_i <= sets;
    cfg_sets    = sets[SetCntW-1:0];
    @(negedge clk_i);
    cfg_idx_i  <= CfgBindingsInUse;
    cfg_data_i <= binds;
    cfg_binds   = binds[VbCntW-1:0];
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // mostly reused handles so that redundant binds actually occur
  task automatic queue_random(int unsigned n);
    int unsigned       r;
    kind_e             k;
    logic [HandleW-1:0] h;
    logic [SlotW-1:0]   s;
    logic [OffsetW-1:0] o;
    logic [IdxKW-1:0]   ik;
    for (int i = 0; i < 4; i++) hdl_pool[i] = rand64();
    off_pool[0]   = '0;
    off_pool[1]   = rand64();
    ikind_pool[0] = IdxKW'($urandom_range(255));
    ikind_pool[1] = IdxKW'($urandom_range(255));
    for (int unsigned i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 20) k = KindPipeline;
      else if (r < 45) k = KindDescSet;
      else if (r < 70) k = KindVertexBuf;
      else if (r < 90) k = KindIndexBuf;
      else if (r < 94) k = KindPushDirty;
      else if (r < 96) k = KindInvalidate;
      else k = KindResetStats;
      r = $urandom_range(99);
      if (r < 60) h = hdl_pool[$urandom_range(3)];
      else if (r < 70) h = '0;
      else if (r < 75) h = '1;
      else h = rand64();
      r = $urandom_range(99);
      if (r < 65) o = off_pool[$urandom_range(1)];
      else if (r < 70) o = '1;
      else o = rand64();
      if ($urandom_range(99) < 70) ik = ikind_pool[$urandom_range(1)];
      else ik = IdxKW'($urandom_range(255));
      if ($urandom_range(99) < 80) s = SlotW'($urandom_range(MaxVbinds + 1));
      else s = SlotW'($urandom_range(255));
      push_cmd(k, h, s, o, ik);
    end
  endtask

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CfgTrackStats;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    kind_i        = KindPipeline;
    handle_i      = '0;
    slot_i        = '0;
    buf_offset_i  = '0;
    index_kind_i  = '0;
    out_ready_i   = 1'b0;
    cmd_taken     = 1'b0;
    hold_req      = 1'b0;
    hold_ack      = 1'b0;
    hold_left     = 0;
    quiet_cycles  = 0;
    fail_count    = 0;
    send_idle_pct = 8;
    recv_idle_pct = 70;
    cfg_track     = 1'b1;
    cfg_sets      = SetCntW'(8);
    cfg_binds     = VbCntW'(16);
    clear_bindings();
    clear_counts();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    program_filter(1'b1, 5'd8, 5'd16);
    // directed: extremes, every kind, handle zero never redundant in set and vertex slots, out-of-range slots
    push_cmd(KindPipeline, '0, 8'd0, '0, 8'd0);
    push_cmd(KindPipeline, '0, 8'd0, '0, 8'd0);
    push_cmd(KindPipeline, '1, 8'd255, '1, 8'd255);
    push_cmd(KindDescSet, '0, 8'd0, '0, 8'd0);
    push_cmd(KindDescSet, '0, 8'd0, '0, 8'd0);
    push_cmd(KindDescSet, '1, 8'd7, '0, 8'd0);
    push_cmd(KindDescSet, '1, 8'd7, '1, 8'd255);
    push_cmd(KindDescSet, 64'h1234, 8'd8, '0, 8'd0);
    push_cmd(KindDescSet, '1, 8'd255, '0, 8'd0);
    push_cmd(KindVertexBuf, 64'hA5A5_5A5A_0F0F_F0F0, 8'd15, '1, 8'd0);
    push_cmd(KindVertexBuf, 64'hA5A5_5A5A_0F0F_F0F0, 8'd15, '1, 8'd0);
    push_cmd(KindVertexBuf, 64'hA5A5_5A5A_0F0F_F0F0, 8'd15, 64'h10, 8'd0);
    push_cmd(KindVertexBuf, '1, 8'd16, '1, 8'd0);
    push_cmd(KindVertexBuf, '0, 8'd0, '0, 8'd0);
    push_cmd(KindVertexBuf, '0, 8'd0, '0, 8'd0);
    push_cmd(KindIndexBuf, '0, 8'd0, '0, 8'd0);
    push_cmd(KindIndexBuf, '0, 8'd0, '0, 8'd0);
    push_cmd(KindIndexBuf, '0, 8'd0, '0, 8'd255);
    push_cmd(KindPushDirty, '1, 8'd7, '1, 8'd255);
    push_cmd(KindInvalidate, '0, 8'd7, '0, 8'd0);
    push_cmd(KindPipeline, '1, 8'd0, '0, 8'd0);
    push_cmd(KindDescSet, '1, 8'd7, '0, 8'd0);
    push_cmd(KindResetStats, '0, 8'd3, '0, 8'd0);
    push_cmd(KindPushDirty, '0, 8'd0, '0, 8'd0);
    drain();

    queue_random(PhaseItems);
    drain();
    // counters frozen, nothing tracked
    program_filter(1'b0, 5'd0, 5'd0);
    queue_random(PhaseItems);
    drain();

    send_idle_pct = 70;
    recv_idle_pct = 8;
    // counts beyond the table sizes clamp
    program_filter(1'b1, 5'd15, 5'd31);
    queue_random(PhaseItems);
    drain();
    program_filter(1'b1, 5'd3, 5'd5);
    queue_random(PhaseItems);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_filter(1'b1, CfgW'($urandom_range(15)), CfgW'($urandom_range(31)));
    @(posedge clk_i);
    hold_req = ~hold_req;
    queue_random(PhaseItems);
    drain();
    // grow back so stale entries return to use
    program_filter(1'b1, 5'd8, 5'd16);
    queue_random(PhaseItems);
    drain();

    if (fail_count == 0 && verdict_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
